// ===== rtl/p6a_pkg.sv =====
// shared types and constants for the 6-bit posit (es = 0) adder
// no dependencies; imported by the decoder, the datapath and the top level
package p6a_pkg;

    localparam int WORD_BITS = 6;

    // special bit patterns
    localparam logic [WORD_BITS-1:0] NAR_PATTERN = 6'b100000;
    localparam logic [WORD_BITS-1:0] ZERO_PATTERN = 6'b000000;
    localparam logic [WORD_BITS-2:0] MAXPOS = 5'b11111;
    localparam logic [WORD_BITS-2:0] MINPOS = 5'b00001;

    // one decoded operand: value is (8 + frac) / 8 * 2^scale
    typedef struct packed {
        logic              sign;
        logic [4:0]        mag;
        logic signed [3:0] scale;
        logic [2:0]        frac;
    } p6a_dec_t;

endpackage

// ===== rtl/p6a_decode.sv =====
// posit operand decoder: sign, magnitude, regime scale, left-aligned fraction
// depends on p6a_pkg
module p6a_decode
    import p6a_pkg::*;
(
    input  logic [WORD_BITS-1:0] posit,
    output p6a_dec_t             dec
);

    logic [WORD_BITS-1:0] mag_full;
    logic                 regime_bit;
    logic [3:0]           run_diff;
    logic [2:0]           run_len;
    logic signed [3:0]    run_s;
    logic [2:0]           frac_bits;

    // two's complement magnitude for negative patterns
    assign mag_full = posit[WORD_BITS-1] ? (ZERO_PATTERN - posit) : posit;
    assign regime_bit = mag_full[4];
    assign run_diff = mag_full[3:0] ^ {4{regime_bit}};

    // regime run length, the top bit always belongs to the run
    always_comb
    begin
        if (run_diff[3])
        begin
            run_len = 3'd1;
        end
        else if (run_diff[2])
        begin
            run_len = 3'd2;
        end
        else if (run_diff[1])
        begin
            run_len = 3'd3;
        end
        else if (run_diff[0])
        begin
            run_len = 3'd4;
        end
        else
        begin
            run_len = 3'd5;
        end
    end

    assign run_s = {1'b0, run_len};

    // fraction bits after the terminator, aligned to the top
    always_comb
    begin
        case (run_len)
            3'd1:    frac_bits = mag_full[2:0];
            3'd2:    frac_bits = {mag_full[1:0], 1'b0};
            3'd3:    frac_bits = {mag_full[0], 2'b00};
            default: frac_bits = 3'b000;
        endcase
    end

    assign dec.sign  = posit[WORD_BITS-1];
    assign dec.mag   = mag_full[4:0];
    assign dec.scale = regime_bit ? (run_s - 4'sd1) : (-run_s);
    assign dec.frac  = frac_bits;

endmodule

// ===== rtl/p6a_core.sv =====
// combinational add path: align, add or subtract, normalize, encode, negate
// depends on p6a_pkg and p6a_decode
module p6a_core
    import p6a_pkg::*;
(
    input  logic [WORD_BITS-1:0] operand_a,
    input  logic [WORD_BITS-1:0] operand_b,
    output logic [WORD_BITS-1:0] sum_posit
);

    p6a_dec_t          dec_a;
    p6a_dec_t          dec_b;
    logic              opposite;
    logic              a_larger;
    logic signed [4:0] kl_ext;
    logic signed [4:0] ks_ext;
    logic signed [4:0] scale_diff;
    logic [3:0]        sig_l;
    logic [3:0]        sig_s;
    logic [3:0]        sig_s_aligned;
    logic              neg;
    logic [4:0]        raw_sum;
    logic [3:0]        norm_sig;
    logic signed [4:0] norm_scale;
    logic [4:0]        enc_mag;
    logic [WORD_BITS-1:0] enc_word;

    p6a_decode u_dec_a
    (
        .posit (operand_a),
        .dec   (dec_a)
    );

    p6a_decode u_dec_b
    (
        .posit (operand_b),
        .dec   (dec_b)
    );

    // pick the larger magnitude, ties go to operand b
    assign opposite = dec_a.sign ^ dec_b.sign;
    assign a_larger = dec_a.mag > dec_b.mag;
    assign kl_ext   = a_larger ? {dec_a.scale[3], dec_a.scale} : {dec_b.scale[3], dec_b.scale};
    assign ks_ext   = a_larger ? {dec_b.scale[3], dec_b.scale} : {dec_a.scale[3], dec_a.scale};
    assign sig_l    = {1'b1, (a_larger ? dec_a.frac : dec_b.frac)};
    assign sig_s    = {1'b1, (a_larger ? dec_b.frac : dec_a.frac)};
    assign neg      = a_larger ? dec_a.sign : dec_b.sign;

    // align the smaller significand, shifted-out bits are dropped
    assign scale_diff = kl_ext - ks_ext;

    always_comb
    begin
        if (scale_diff < 5'sd0)
        begin
            sig_s_aligned = sig_s;
        end
        else if (scale_diff >= 5'sd4)
        begin
            sig_s_aligned = 4'd0;
        end
        else
        begin
            sig_s_aligned = sig_s >> scale_diff[1:0];
        end
    end

    assign raw_sum = opposite ? ({1'b0, sig_l} - {1'b0, sig_s_aligned})
                              : ({1'b0, sig_l} + {1'b0, sig_s_aligned});

    // normalize to a leading one in bit 3
    always_comb
    begin
        if (raw_sum[4])
        begin
            norm_sig   = raw_sum[4:1];
            norm_scale = kl_ext + 5'sd1;
        end
        else if (raw_sum[3])
        begin
            norm_sig   = raw_sum[3:0];
            norm_scale = kl_ext;
        end
        else if (raw_sum[2])
        begin
            norm_sig   = {raw_sum[2:0], 1'b0};
            norm_scale = kl_ext - 5'sd1;
        end
        else if (raw_sum[1])
        begin
            norm_sig   = {raw_sum[1:0], 2'b00};
            norm_scale = kl_ext - 5'sd2;
        end
        else if (raw_sum[0])
        begin
            norm_sig   = {raw_sum[0], 3'b000};
            norm_scale = kl_ext - 5'sd3;
        end
        else
        begin
            norm_sig   = 4'd0;
            norm_scale = kl_ext;
        end
    end

    // regime encode with truncated fraction, saturating at both ends
    always_comb
    begin
        case (norm_scale)
            5'sd4:   enc_mag = MAXPOS;
            5'sd3:   enc_mag = 5'b11110;
            5'sd2:   enc_mag = {4'b1110, norm_sig[2]};
            5'sd1:   enc_mag = {3'b110, norm_sig[2:1]};
            5'sd0:   enc_mag = {2'b10, norm_sig[2:0]};
            -5'sd1:  enc_mag = {2'b01, norm_sig[2:0]};
            -5'sd2:  enc_mag = {3'b001, norm_sig[2:1]};
            -5'sd3:  enc_mag = {4'b0001, norm_sig[2]};
            -5'sd4:  enc_mag = MINPOS;
            default: enc_mag = norm_scale[4] ? MINPOS : MAXPOS;
        endcase
    end

    assign enc_word = neg ? (ZERO_PATTERN - {1'b0, enc_mag}) : {1'b0, enc_mag};

    // special cases ahead of the arithmetic result
    always_comb
    begin
        if (operand_a == NAR_PATTERN || operand_b == NAR_PATTERN)
        begin
            sum_posit = NAR_PATTERN;
        end
        else if (operand_a == ZERO_PATTERN)
        begin
            sum_posit = operand_b;
        end
        else if (operand_b == ZERO_PATTERN)
        begin
            sum_posit = operand_a;
        end
        else if (opposite && dec_a.mag == dec_b.mag)
        begin
            sum_posit = ZERO_PATTERN;
        end
        else
        begin
            sum_posit = enc_word;
        end
    end

endmodule

// ===== rtl/posit6_es0_adder.sv =====
// top level of the 6-bit posit (es = 0) adder: operand register, add path, result register
// depends on p6a_pkg and p6a_core
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  request  | in_valid, in_stall, operand_a/b  | in
//  result   | out_valid, out_stall, sum_posit  | out
//
// one request per cycle sustained while out_stall is low
// the operand register feeds the combinational add path into the result register
// rst_n clears both valid flags asynchronously; payload registers are not reset
// a stalled result holds, and a new request is still taken while the operand
// register is empty or moving forward
module posit6_es0_adder
    import p6a_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_BITS-1:0] operand_a,
    input  logic [WORD_BITS-1:0] operand_b,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_BITS-1:0] sum_posit
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] a_next;
    logic [WORD_BITS-1:0] b_reg;
    logic [WORD_BITS-1:0] b_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WORD_BITS-1:0] sum_reg;
    logic [WORD_BITS-1:0] sum_next;
    logic [WORD_BITS-1:0] core_sum;
    logic                 out_load;
    logic                 in_take;

    // handshake control
    assign out_load = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    p6a_core u_core
    (
        .operand_a (a_reg),
        .operand_b (b_reg),
        .sum_posit (core_sum)
    );

    // next values for both stages
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg;
        sum_next       = sum_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
            a_next        = operand_a;
            b_next        = operand_b;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                sum_next = core_sum;
            end
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        sum_reg <= sum_next;
    end

    assign out_valid = out_valid_reg;
    assign sum_posit = sum_reg;

endmodule
